// File: hdl/jmhp_pkg.sv
package jmhp_pkg;

    // Marker bytes of interest.
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_DRI    = 8'hDD;
    localparam logic [7:0] MARK_STUFF  = 8'h00;

    // Parser phases.
    localparam logic [2:0] PH_SOI0 = 3'd0;
    localparam logic [2:0] PH_SOI1 = 3'd1;
    localparam logic [2:0] PH_MK0  = 3'd2;
    localparam logic [2:0] PH_MK1  = 3'd3;
    localparam logic [2:0] PH_LEN0 = 3'd4;
    localparam logic [2:0] PH_LEN1 = 3'd5;
    localparam logic [2:0] PH_BODY = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    // Stop causes.
    localparam logic [1:0] CAUSE_END    = 2'd0;
    localparam logic [1:0] CAUSE_EOI    = 2'd1;
    localparam logic [1:0] CAUSE_SOS    = 2'd2;
    localparam logic [1:0] CAUSE_NOMARK = 2'd3;

    // Minimum segment lengths for captures.
    localparam logic [15:0] SOF0_MIN_LEN = 16'd8;
    localparam logic [15:0] DRI_MIN_LEN  = 16'd4;
    localparam logic [15:0] LEN_FIELD    = 16'd2;

    typedef struct packed {
        logic        status;
        logic [1:0]  stop_cause;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
        logic [7:0]  component_count;
        logic [15:0] restart_mcus;
    } t_result;

endpackage

// File: hdl/jmhp_ifs.sv
interface jmhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jmhp_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  stop_cause;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [7:0]  component_count;
    logic [15:0] restart_mcus;

    modport source (output valid, output status, output stop_cause, output frame_height,
                    output frame_width, output component_count,
                    output restart_mcus, input ready);
    modport sink (input valid, input status, input stop_cause, input frame_height,
                  input frame_width, input component_count, input restart_mcus,
                  output ready);
endinterface

// File: hdl/jmhp_parse.sv
module jmhp_parse
    import jmhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_result    o_result
);

    logic [2:0]  r_phase,   n_phase;
    logic [15:0] r_offset,  n_offset;
    logic [15:0] r_length,  n_length;
    logic [7:0]  r_marker,  n_marker;
    logic [15:0] r_height,  n_height;
    logic [15:0] r_width,   n_width;
    logic [7:0]  r_comps,   n_comps;
    logic [15:0] r_restart, n_restart;
    logic [1:0]  r_cause,   n_cause;
    logic        r_status,  n_status;

    logic [16:0] offset_inc;
    logic [15:0] len_full;
    logic        bad_start;

    assign offset_inc = {1'b0, r_offset} + 17'd1;
    assign len_full   = {r_length[15:8], i_data_byte};

    always_comb begin
        n_phase   = r_phase;
        n_offset  = r_offset;
        n_length  = r_length;
        n_marker  = r_marker;
        n_height  = r_height;
        n_width   = r_width;
        n_comps   = r_comps;
        n_restart = r_restart;
        n_cause   = r_cause;
        n_status  = r_status;

        unique case (r_phase)
            PH_SOI0: begin
                if (i_data_byte == MARK_PREFIX) begin
                    n_phase = PH_SOI1;
                end else begin
                    n_status = 1'b1;
                    n_phase  = PH_DONE;
                end
            end
            PH_SOI1: begin
                if (i_data_byte == MARK_SOI) begin
                    n_phase = PH_MK0;
                end else begin
                    n_status = 1'b1;
                    n_phase  = PH_DONE;
                end
            end
            PH_MK0: begin
                if (i_data_byte == MARK_PREFIX) begin
                    n_phase = PH_MK1;
                end else if (!i_last_byte) begin
                    n_cause = CAUSE_NOMARK;
                    n_phase = PH_DONE;
                end
            end
            PH_MK1: begin
                if (i_data_byte == MARK_EOI) begin
                    n_cause = CAUSE_EOI;
                    n_phase = PH_DONE;
                end else if (i_data_byte == MARK_SOS) begin
                    n_cause = CAUSE_SOS;
                    n_phase = PH_DONE;
                end else if (i_data_byte == MARK_STUFF) begin
                    n_cause = CAUSE_NOMARK;
                    n_phase = PH_DONE;
                end else begin
                    n_marker = i_data_byte;
                    n_phase  = PH_LEN0;
                end
            end
            PH_LEN0: begin
                n_length = {i_data_byte, 8'h00};
                n_phase  = PH_LEN1;
            end
            PH_LEN1: begin
                n_length = len_full;
                if (len_full < LEN_FIELD) begin
                    n_cause = CAUSE_NOMARK;
                    n_phase = PH_DONE;
                end else begin
                    n_offset = LEN_FIELD;
                    n_phase  = (len_full == LEN_FIELD) ? PH_MK0 : PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_marker == MARK_SOF0 && r_length >= SOF0_MIN_LEN) begin
                    case (r_offset)
                        16'd3:   n_height[15:8] = i_data_byte;
                        16'd4:   n_height[7:0]  = i_data_byte;
                        16'd5:   n_width[15:8]  = i_data_byte;
                        16'd6:   n_width[7:0]   = i_data_byte;
                        16'd7:   n_comps        = i_data_byte;
                        default: ;
                    endcase
                end else if (r_marker == MARK_DRI && r_length >= DRI_MIN_LEN) begin
                    case (r_offset)
                        16'd2:   n_restart[15:8] = i_data_byte;
                        16'd3:   n_restart[7:0]  = i_data_byte;
                        default: ;
                    endcase
                end
                // The offset stays below the length here, so the sum fits 16 bits.
                n_offset = offset_inc[15:0];
                if (offset_inc >= {1'b0, r_length}) begin
                    n_phase = PH_MK0;
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    // A file that ends before the start marker is complete also counts as a bad start.
    assign bad_start = n_status || n_phase == PH_SOI0 || n_phase == PH_SOI1;

    always_comb begin
        if (bad_start) begin
            o_result = '0;
            o_result.status = 1'b1;
        end else begin
            o_result.status          = 1'b0;
            o_result.stop_cause      = (n_phase == PH_DONE) ? n_cause : CAUSE_END;
            o_result.frame_height    = n_height;
            o_result.frame_width     = n_width;
            o_result.component_count = n_comps;
            o_result.restart_mcus    = n_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_phase   <= PH_SOI0;
            r_offset  <= '0;
            r_length  <= '0;
            r_marker  <= '0;
            r_height  <= '0;
            r_width   <= '0;
            r_comps   <= '0;
            r_restart <= '0;
            r_cause   <= CAUSE_END;
            r_status  <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_length  <= n_length;
            r_marker  <= n_marker;
            r_height  <= n_height;
            r_width   <= n_width;
            r_comps   <= n_comps;
            r_restart <= n_restart;
            r_cause   <= n_cause;
            r_status  <= n_status;
        end
    end

endmodule

// File: hdl/jmhp_out_reg.sv
module jmhp_out_reg
    import jmhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_can_load,
    jmhp_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    // A new result may enter when the register is empty or being drained.
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.status          = r_result.status;
    assign o_out.stop_cause      = r_result.stop_cause;
    assign o_out.frame_height    = r_result.frame_height;
    assign o_out.frame_width     = r_result.frame_width;
    assign o_out.component_count = r_result.component_count;
    assign o_out.restart_mcus    = r_result.restart_mcus;

endmodule

// File: hdl/jpeg_marker_header_parser.sv
// Channel  Direction  Payload                                         Transfer
// i_in     sink       data_byte[7:0], last_byte                       valid && ready
// o_out    source     status, stop_cause[1:0], frame_height[15:0],    valid && ready
//                     frame_width[15:0], component_count[7:0],
//                     restart_mcus[15:0]
//
// One byte is taken per clock unless stalled; parser state updates on each input transfer.
// A byte marked last produces one result, which appears on o_out in the cycle after
// its transfer; other bytes produce nothing.
// Reset (i_rst_n low at a clock edge) returns the parser to waiting for the start
// marker and empties the result register.
// Input is stalled only while a result is held and o_out.ready is low.
module jpeg_marker_header_parser
    import jmhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    jmhp_in_if.sink    i_in,
    jmhp_out_if.source o_out
);

    t_result result;
    logic    can_load;
    logic    take;

    // A byte is taken whenever the result register could absorb a result.
    assign i_in.ready = can_load;
    assign take       = i_in.valid && can_load;

    // Marker walk and field capture; the result reflects the state after this byte.
    jmhp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_result    (result)
    );

    // Result register that decouples the output handshake from the input.
    jmhp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && i_in.last_byte),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule
